[hw/rtl/tsxd_pkg.sv]
// ----------------------------------------------------------------------------
// tsxd_pkg: shared types and codes of the XOR/delta sample compressor
// Job descriptor passed from the classifier to the chunk sequencer.
// ----------------------------------------------------------------------------
package tsxd_pkg;

	localparam int          QUEUE_DEPTH    = 4;
	localparam logic [11:0] CAPACITY_RESET = 12'd408;

	// job kinds
	localparam logic [1:0] KIND_REJECT = 2'd0;
	localparam logic [1:0] KIND_FIRST  = 2'd1;
	localparam logic [1:0] KIND_CODED  = 2'd2;

	// value code forms
	localparam logic [1:0] VF_ZERO = 2'd0;
	localparam logic [1:0] VF_SAME = 2'd1;
	localparam logic [1:0] VF_NEW  = 2'd2;

	// time code forms
	localparam logic [2:0] TF_D20  = 3'd0;
	localparam logic [2:0] TF_ZERO = 3'd1;
	localparam logic [2:0] TF_DD7  = 3'd2;
	localparam logic [2:0] TF_DD9  = 3'd3;
	localparam logic [2:0] TF_DD12 = 3'd4;
	localparam logic [2:0] TF_DD32 = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  vform;
		logic [4:0]  lead;
		logic [5:0]  mlen;
		logic [31:0] mbits;
		logic [2:0]  tform;
		logic [31:0] tval;
	} job_t;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  length;
	} chunk_t;

endpackage

[hw/rtl/tsxd_if.sv]
// ----------------------------------------------------------------------------
// tsxd_if: valid/ready channels of the sample compressor
// Sample input channel and chunk output channel.
// ----------------------------------------------------------------------------
interface tsxd_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] timestamp;
	logic        [31:0] value_bits;

	modport source (output valid, output timestamp, output value_bits, input ready);
	modport sink   (input valid, input timestamp, input value_bits, output ready);
endinterface

interface tsxd_chunk_if;
	logic        valid;
	logic        ready;
	logic [31:0] chunk_value;
	logic [5:0]  chunk_length;
	logic        rejected;
	logic        last;

	modport source (output valid, output chunk_value, output chunk_length,
		output rejected, output last, input ready);
	modport sink   (input valid, input chunk_value, input chunk_length,
		input rejected, input last, output ready);
endinterface

[hw/rtl/tsxd_front.sv]
// ----------------------------------------------------------------------------
// tsxd_front: sample classifier
// Accepts one sample per cycle unless queue_full; computes XOR, delta-of-delta
// forms, checks the bit budget, updates history and emits a job descriptor.
// ----------------------------------------------------------------------------
module tsxd_front
	import tsxd_pkg::*;
#(
	parameter int MAX_CAPACITY_BITS = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [11:0]        cfg_wdata,
	tsxd_sample_if.sink        sample_in,
	input  logic               queue_full,
	output logic               push,
	output job_t               job
);

	localparam int CAP_MAX = (MAX_CAPACITY_BITS > 4095) ? 4095 : MAX_CAPACITY_BITS;
	localparam int USED_W  = $clog2(CAP_MAX + 1);
	localparam int SUM_W   = $clog2(CAP_MAX + 128);
	localparam logic [11:0] CAP_LIMIT = CAP_MAX[11:0];

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_MANY = 2'd2;

	function automatic logic [5:0] lead_zeros(input logic [31:0] v);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) n = 6'(31 - i);
		end
		return n;
	endfunction

	function automatic logic [5:0] trail_zeros(input logic [31:0] v);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) n = 6'(i);
		end
		return n;
	endfunction

	logic [11:0]       capacity_q;
	logic [1:0]        seen_q;
	logic [31:0]       prev_time_q;
	logic [31:0]       prev_delta_q;
	logic [31:0]       prev_value_q;
	logic [5:0]        prev_lead_q;
	logic [5:0]        prev_trail_q;
	logic [USED_W-1:0] used_q;
	logic              full_q;

	logic [11:0]        cap_eff;
	logic [31:0]        t_u;
	logic [31:0]        delta;
	logic [31:0]        udd;
	logic signed [31:0] sdd;
	logic [31:0]        x;
	logic [5:0]         x_lead;
	logic [5:0]         x_trail;
	logic               x_zero;
	logic               same_win;
	logic [5:0]         len_same;
	logic [5:0]         len_new;
	logic [5:0]         mlen;
	logic [2:0]         tform;
	logic [5:0]         tbits;
	logic [5:0]         vbits;
	logic [6:0]         need;
	logic [SUM_W-1:0]   sum;
	logic               first;
	logic               reject;

	assign sample_in.ready = !queue_full;
	assign push            = sample_in.valid && !queue_full;

	assign cap_eff = (capacity_q > CAP_LIMIT) ? CAP_LIMIT : capacity_q;
	assign t_u     = sample_in.timestamp;
	assign delta   = t_u - prev_time_q;
	assign udd     = delta - prev_delta_q;
	assign sdd     = udd;
	assign x       = sample_in.value_bits ^ prev_value_q;
	assign x_lead  = lead_zeros(x);
	assign x_trail = trail_zeros(x);
	assign x_zero  = (x == 32'd0);
	assign first   = (seen_q == SEEN_NONE);

	// window reuse: trailing zeros equal, so the shift amount is the same
	assign same_win = (seen_q == SEEN_MANY) && !x_zero &&
		(x_lead >= prev_lead_q) && (x_trail == prev_trail_q);
	assign len_same = 6'd32 - prev_lead_q - prev_trail_q;
	assign len_new  = 6'd32 - x_lead - x_trail;
	assign mlen     = same_win ? len_same : len_new;

	always_comb begin
		if (seen_q == SEEN_ONE) begin
			tform = TF_D20;
			tbits = 6'd20;
		end else if (sdd == 32'sd0) begin
			tform = TF_ZERO;
			tbits = 6'd1;
		end else if (sdd >= -32'sd63 && sdd <= 32'sd64) begin
			tform = TF_DD7;
			tbits = 6'd9;
		end else if (sdd >= -32'sd255 && sdd <= 32'sd256) begin
			tform = TF_DD9;
			tbits = 6'd12;
		end else if (sdd >= -32'sd2047 && sdd <= 32'sd2048) begin
			tform = TF_DD12;
			tbits = 6'd16;
		end else begin
			tform = TF_DD32;
			tbits = 6'd36;
		end
	end

	always_comb begin
		if (x_zero) vbits = 6'd1;
		else if (same_win) vbits = 6'd2 + len_same;
		else vbits = 6'd13 + len_new;
	end

	assign need   = first ? 7'd64 : (7'(tbits) + 7'(vbits));
	assign sum    = SUM_W'(used_q) + SUM_W'(need);
	assign reject = full_q || (sum > SUM_W'(cap_eff));

	always_comb begin
		job       = '0;
		job.lead  = x_lead[4:0];
		job.mlen  = mlen;
		job.mbits = x >> x_trail;
		job.tform = tform;
		if (x_zero) job.vform = VF_ZERO;
		else if (same_win) job.vform = VF_SAME;
		else job.vform = VF_NEW;
		case (tform)
			TF_D20:  job.tval = {12'd0, delta[19:0]};
			TF_ZERO: job.tval = 32'd0;
			TF_DD7:  job.tval = {25'd0, udd[6:0]};
			TF_DD9:  job.tval = {23'd0, udd[8:0]};
			TF_DD12: job.tval = {20'd0, udd[11:0]};
			default: job.tval = udd;
		endcase
		if (reject) begin
			job.kind = KIND_REJECT;
		end else if (first) begin
			job.kind  = KIND_FIRST;
			job.mbits = sample_in.value_bits;
			job.tval  = t_u;
		end else begin
			job.kind = KIND_CODED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RESET;
			seen_q       <= SEEN_NONE;
			prev_time_q  <= '0;
			prev_delta_q <= '0;
			prev_value_q <= '0;
			prev_lead_q  <= 6'd32;
			prev_trail_q <= 6'd32;
			used_q       <= '0;
			full_q       <= 1'b0;
		end else begin
			if (cfg_we) capacity_q <= cfg_wdata;
			if (push) begin
				if (reject) begin
					full_q <= 1'b1;
				end else begin
					used_q       <= sum[USED_W-1:0];
					prev_time_q  <= t_u;
					prev_value_q <= sample_in.value_bits;
					// history of the first sample is its raw value (x == value here)
					prev_lead_q  <= x_lead;
					prev_trail_q <= x_trail;
					if (first) begin
						seen_q <= SEEN_ONE;
					end else begin
						seen_q       <= SEEN_MANY;
						prev_delta_q <= delta;
					end
				end
			end
		end
	end

endmodule

[hw/rtl/tsxd_queue.sv]
// ----------------------------------------------------------------------------
// tsxd_queue: job queue
// Small FIFO of job descriptors between classifier and sequencer.
// ----------------------------------------------------------------------------
module tsxd_queue
	import tsxd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output job_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

[hw/rtl/tsxd_back.sv]
// ----------------------------------------------------------------------------
// tsxd_back: chunk sequencer
// Expands the head job into its chunks, one per cycle while chunk_out is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module tsxd_back
	import tsxd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	input  job_t         job,
	output logic         pop,
	tsxd_chunk_if.source chunk_out
);

	chunk_t     vc [4];
	chunk_t     tc [2];
	chunk_t     cur;
	logic [2:0] nv;
	logic [1:0] nt;
	logic [2:0] n;
	logic [2:0] step_q;
	logic [2:0] tstep;
	logic       last_step;
	logic       load;
	logic       out_valid_q;

	always_comb begin
		for (int i = 0; i < 4; i++) vc[i] = '0;
		for (int i = 0; i < 2; i++) tc[i] = '0;
		nv = 3'd1;
		nt = 2'd1;
		case (job.kind)
			KIND_REJECT: begin
				nt = 2'd0;
			end
			KIND_FIRST: begin
				vc[0] = '{value: job.mbits, length: 6'd32};
				tc[0] = '{value: job.tval, length: 6'd32};
			end
			default: begin
				case (job.vform)
					VF_ZERO: begin
						vc[0] = '{value: 32'd0, length: 6'd1};
					end
					VF_SAME: begin
						nv    = 3'd2;
						vc[0] = '{value: 32'd2, length: 6'd2};
						vc[1] = '{value: job.mbits, length: job.mlen};
					end
					default: begin
						nv    = 3'd4;
						vc[0] = '{value: 32'd3, length: 6'd2};
						vc[1] = '{value: {27'd0, job.lead}, length: 6'd5};
						vc[2] = '{value: {26'd0, job.mlen}, length: 6'd6};
						vc[3] = '{value: job.mbits, length: job.mlen};
					end
				endcase
				case (job.tform)
					TF_D20: begin
						tc[0] = '{value: job.tval, length: 6'd20};
					end
					TF_ZERO: begin
						tc[0] = '{value: 32'd0, length: 6'd1};
					end
					TF_DD7: begin
						nt    = 2'd2;
						tc[0] = '{value: 32'd2, length: 6'd2};
						tc[1] = '{value: job.tval, length: 6'd7};
					end
					TF_DD9: begin
						nt    = 2'd2;
						tc[0] = '{value: 32'd6, length: 6'd3};
						tc[1] = '{value: job.tval, length: 6'd9};
					end
					TF_DD12: begin
						nt    = 2'd2;
						tc[0] = '{value: 32'd14, length: 6'd4};
						tc[1] = '{value: job.tval, length: 6'd12};
					end
					default: begin
						nt    = 2'd2;
						tc[0] = '{value: 32'd15, length: 6'd4};
						tc[1] = '{value: job.tval, length: 6'd32};
					end
				endcase
			end
		endcase
	end

	assign n         = nv + 3'(nt);
	assign tstep     = step_q - nv;
	assign cur       = (step_q < nv) ? vc[step_q[1:0]] : tc[tstep[0]];
	assign last_step = (step_q == n - 3'd1);
	assign load      = job_valid && (!out_valid_q || chunk_out.ready);
	assign pop       = load && last_step;

	assign chunk_out.valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			chunk_out.chunk_value  <= cur.value;
			chunk_out.chunk_length <= cur.length;
			chunk_out.rejected     <= (job.kind == KIND_REJECT);
			chunk_out.last         <= last_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= last_step ? 3'd0 : step_q + 3'd1;
			end else if (chunk_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/time_series_xor_delta_compressor_unit.sv]
// ----------------------------------------------------------------------------
// time_series_xor_delta_compressor_unit: XOR/delta sample compressor
// Codes each (timestamp, value) sample into MSB-first bit chunks against a
// bit budget; once a sample does not fit every later sample is rejected.
//
//   channel     dir   payload                                        handshake
//   sample_in   in    timestamp, value_bits                          valid/ready
//   chunk_out   out   chunk_value, chunk_length, rejected, last      valid/ready
//   cfg         in    cfg_wdata (capacity_bits)                      cfg_we
//
// The classifier takes one sample per cycle while the job queue has room.
// The chunk sequencer sets the rate, one chunk per cycle unless stalled:
// 1 chunk for a reject, 2 for the first sample, up to 6 for a coded sample.
// A 4-entry job queue lets the input side run ahead of a stalled output.
// arst_n clears history, budget and full state; capacity resets to 408.
// ----------------------------------------------------------------------------
module time_series_xor_delta_compressor_unit
	import tsxd_pkg::*;
#(
	parameter int MAX_CAPACITY_BITS = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [11:0]  cfg_wdata,
	tsxd_sample_if.sink  sample_in,
	tsxd_chunk_if.source chunk_out
);

	logic push;
	logic pop;
	logic queue_full;
	logic queue_not_empty;
	job_t push_job;
	job_t head_job;

	tsxd_front #(
		.MAX_CAPACITY_BITS(MAX_CAPACITY_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (sample_in),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	tsxd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head      (head_job)
	);

	tsxd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (queue_not_empty),
		.job       (head_job),
		.pop       (pop),
		.chunk_out (chunk_out)
	);

endmodule

[hw/rtl/tsxd_checker.sv]
// ----------------------------------------------------------------------------
// tsxd_checker: port-level checks of the sample compressor
// Reject format, chunk lengths, sticky full state and transaction ordering.
// ----------------------------------------------------------------------------
module tsxd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] chunk_value,
	input logic [5:0]  chunk_length,
	input logic        rejected,
	input logic        last
);

	logic [3:0] pending_q;
	logic       seen_reject_q;
	logic       in_acc;
	logic       out_done;

	assign in_acc   = in_valid && in_ready;
	assign out_done = out_valid && out_ready && last;

	// samples accepted whose final chunk has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			seen_reject_q <= 1'b0;
		end else begin
			if (in_acc && !out_done) pending_q <= pending_q + 4'd1;
			else if (!in_acc && out_done) pending_q <= pending_q - 4'd1;
			if (out_valid && out_ready && rejected) seen_reject_q <= 1'b1;
		end
	end

	a_reject_format: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> chunk_length == 6'd0 && last)
		else $error("reject transaction not a single empty chunk");

	a_chunk_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rejected |-> chunk_length != 6'd0 && chunk_length <= 6'd32)
		else $error("coded chunk length out of range");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_reject_q |-> rejected)
		else $error("coded chunk after a reject");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_done |-> pending_q != 4'd0)
		else $error("final chunk without an accepted sample");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_value) &&
			$stable(chunk_length))
		else $error("stalled chunk changed");

endmodule

bind time_series_xor_delta_compressor_unit tsxd_checker u_tsxd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (sample_in.valid),
	.in_ready     (sample_in.ready),
	.out_valid    (chunk_out.valid),
	.out_ready    (chunk_out.ready),
	.chunk_value  (chunk_out.chunk_value),
	.chunk_length (chunk_out.chunk_length),
	.rejected     (chunk_out.rejected),
	.last         (chunk_out.last)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the XOR/delta sample compressor
// Feeds (timestamp, value) samples over valid/ready with random gaps and a
// long output stall, predicts the chunk stream of every accepted sample and
// checks each chunk field by field. The bit budget is moved through several
// capacities, the smallest and an oversized one included, until it runs full.
// ----------------------------------------------------------------------------
module tb_top;
	import tsxd_pkg::*;

	localparam int CAP_LIMIT     = 2048;
	localparam int HOLD_CYCLES   = 80;
	localparam int STUCK_LIMIT   = 2000;
	localparam int SAMPLE_TARGET = 220;

	// code prefixes
	localparam logic [1:0] PREFIX_SAME = 2'b10;
	localparam logic [1:0] PREFIX_NEW  = 2'b11;
	localparam logic [1:0] PREFIX_DD7  = 2'b10;
	localparam logic [2:0] PREFIX_DD9  = 3'b110;
	localparam logic [3:0] PREFIX_DD12 = 4'b1110;
	localparam logic [3:0] PREFIX_DD32 = 4'b1111;

	typedef struct {
		logic [31:0] timestamp;
		logic [31:0] value_bits;
	} sample_t;

	typedef struct {
		logic [31:0] value;
		logic [5:0]  length;
		logic        rejected;
		logic        last;
	} chunk_exp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [11:0] cfg_wdata;

	tsxd_sample_if sample_bus ();
	tsxd_chunk_if  chunk_bus ();

	time_series_xor_delta_compressor_unit #(
		.MAX_CAPACITY_BITS(CAP_LIMIT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_in (sample_bus),
		.chunk_out (chunk_bus)
	);

	always #5 clk = ~clk;

	sample_t    pending_samples[$];
	chunk_exp_t expected_chunks[$];
	chunk_exp_t want;

	int  samples_taken = 0;
	int  mismatches    = 0;
	int  stuck_cycles  = 0;
	int  hold_left     = 0;
	bit  hold_armed    = 1'b0;
	bit  hold_done     = 1'b0;

	logic sample_fire;
	logic chunk_fire;
	logic calm_window;

	assign sample_fire = sample_bus.valid && sample_bus.ready;
	assign chunk_fire  = chunk_bus.valid && chunk_bus.ready;
	assign calm_window = (samples_taken >= 60) && (samples_taken < 110);

	// ------------------------------------------------------------------
	// predictor state
	// ------------------------------------------------------------------
	logic [11:0] cap_model     = CAPACITY_RESET;
	int unsigned samples_model = 0;
	logic [31:0] prev_time     = '0;
	logic [31:0] prev_delta    = '0;
	logic [31:0] prev_value    = '0;
	logic [31:0] prev_xor      = '0;
	int unsigned used_bits     = 0;
	bit          full_model    = 1'b0;

	function automatic int unsigned lead_zeros(logic [31:0] w);
		for (int i = 31; i >= 0; i--)
			if (w[i]) return 31 - i;
		return 32;
	endfunction

	function automatic int unsigned trail_zeros(logic [31:0] w);
		for (int i = 0; i < 32; i++)
			if (w[i]) return i;
		return 32;
	endfunction

	function automatic chunk_exp_t code_chunk(logic [31:0] bits, int unsigned len);
		chunk_exp_t c;
		c.value    = (len >= 32) ? bits : (bits & ((32'd1 << len) - 32'd1));
		c.length   = 6'(len);
		c.rejected = 1'b0;
		c.last     = 1'b0;
		return c;
	endfunction

	task automatic reject_sample();
		chunk_exp_t c;
		c.value    = '0;
		c.length   = '0;
		c.rejected = 1'b1;
		c.last     = 1'b1;
		full_model = 1'b1;
		expected_chunks.push_back(c);
	endtask

	task automatic encode_sample(input logic [31:0] ts, input logic [31:0] vb);
		int unsigned cap, tbits, vbits, lead, trail, mlen;
		logic [31:0] delta, x, udd;
		int          dd;
		logic [1:0]  vform;
		logic [2:0]  tform;
		chunk_exp_t  seq[$];
		cap   = (cap_model > CAP_LIMIT) ? CAP_LIMIT : cap_model;
		delta = ts - prev_time;
		x     = vb ^ prev_value;
		udd   = delta - prev_delta;
		dd    = $signed(udd);
		if (full_model) begin
			reject_sample();
			return;
		end
		if (samples_model == 0) begin
			if (used_bits + 64 > cap) begin
				reject_sample();
				return;
			end
			used_bits += 64;
			seq.push_back(code_chunk(vb, 32));
			seq.push_back(code_chunk(ts, 32));
			prev_value    = vb;
			prev_xor      = vb;
			prev_time     = ts;
			samples_model = 1;
		end else begin
			if (samples_model == 1) begin
				tform = TF_D20;  tbits = 20;
			end else if (dd == 0) begin
				tform = TF_ZERO; tbits = 1;
			end else if (dd >= -63 && dd <= 64) begin
				tform = TF_DD7;  tbits = 9;
			end else if (dd >= -255 && dd <= 256) begin
				tform = TF_DD9;  tbits = 12;
			end else if (dd >= -2047 && dd <= 2048) begin
				tform = TF_DD12; tbits = 16;
			end else begin
				tform = TF_DD32; tbits = 36;
			end

			lead  = lead_zeros(x);
			trail = trail_zeros(x);
			if (x == 0) begin
				vform = VF_ZERO;
				mlen  = 0;
				vbits = 1;
			end else if (samples_model == 2 && lead >= lead_zeros(prev_xor) &&
					trail == trail_zeros(prev_xor)) begin
				vform = VF_SAME;
				mlen  = 32 - lead_zeros(prev_xor) - trail;
				vbits = 2 + mlen;
			end else begin
				vform = VF_NEW;
				mlen  = 32 - lead - trail;
				vbits = 13 + mlen;
			end

			if (used_bits + tbits + vbits > cap) begin
				reject_sample();
				return;
			end
			used_bits += tbits + vbits;

			case (vform)
				VF_ZERO: seq.push_back(code_chunk(32'd0, 1));
				VF_SAME: begin
					seq.push_back(code_chunk(PREFIX_SAME, 2));
					seq.push_back(code_chunk(x >> trail, mlen));
				end
				default: begin
					seq.push_back(code_chunk(PREFIX_NEW, 2));
					seq.push_back(code_chunk(lead, 5));
					seq.push_back(code_chunk(mlen, 6));
					seq.push_back(code_chunk(x >> trail, mlen));
				end
			endcase

			case (tform)
				TF_D20:  seq.push_back(code_chunk(delta, 20));
				TF_ZERO: seq.push_back(code_chunk(32'd0, 1));
				TF_DD7: begin
					seq.push_back(code_chunk(PREFIX_DD7, 2));
					seq.push_back(code_chunk(udd, 7));
				end
				TF_DD9: begin
					seq.push_back(code_chunk(PREFIX_DD9, 3));
					seq.push_back(code_chunk(udd, 9));
				end
				TF_DD12: begin
					seq.push_back(code_chunk(PREFIX_DD12, 4));
					seq.push_back(code_chunk(udd, 12));
				end
				default: begin
					seq.push_back(code_chunk(PREFIX_DD32, 4));
					seq.push_back(code_chunk(udd, 32));
				end
			endcase

			prev_delta    = delta;
			prev_time     = ts;
			prev_value    = vb;
			prev_xor      = x;
			samples_model = 2;
		end
		seq[seq.size() - 1].last = 1'b1;
		foreach (seq[i]) expected_chunks.push_back(seq[i]);
	endtask

	// ------------------------------------------------------------------
	// sample generator: tracks the history it has queued so that most
	// samples form regular series
	// ------------------------------------------------------------------
	logic [31:0] gen_time   = '0;
	logic [31:0] gen_delta  = '0;
	logic [31:0] gen_value  = '0;
	logic [31:0] gen_xor    = '0;
	int          gen_count  = 0;

	task automatic queue_sample(input logic [31:0] ts, input logic [31:0] vb);
		sample_t s;
		s.timestamp  = ts;
		s.value_bits = vb;
		if (gen_count == 0) begin
			gen_xor = vb;
		end else begin
			gen_delta = ts - gen_time;
			gen_xor   = vb ^ gen_value;
		end
		gen_time  = ts;
		gen_value = vb;
		gen_count++;
		pending_samples.push_back(s);
	endtask

	task automatic queue_delta_sample(input int dd, input logic [31:0] x);
		queue_sample(gen_time + gen_delta + 32'(dd), gen_value ^ x);
	endtask

	task automatic queue_random_sample();
		int          r, dd;
		int unsigned w, lz, tz;
		logic [31:0] x, mask;
		r = $urandom_range(99);
		if (r < 4) begin
			// out-of-series noise
			queue_sample($urandom, $urandom);
			return;
		end
		r = $urandom_range(99);
		if (r < 45) begin
			x = '0;
		end else if (r < 75 && gen_xor != 0) begin
			lz   = lead_zeros(gen_xor);
			tz   = trail_zeros(gen_xor);
			mask = (32'hFFFF_FFFF >> lz) & (32'hFFFF_FFFF << tz);
			x    = ($urandom & mask) | (32'd1 << tz);
		end else if (r < 95) begin
			w = $urandom_range(8, 1);
			x = 32'($urandom_range((1 << w) - 1, 1)) << $urandom_range(32 - w, 0);
		end else begin
			x = $urandom;
		end
		r = $urandom_range(99);
		if (r < 55)
			dd = 0;
		else if (r < 80)
			dd = int'($urandom_range(127)) - 63;
		else if (r < 88)
			dd = $urandom_range(1) ? int'($urandom_range(256, 65)) : -int'($urandom_range(255, 64));
		else if (r < 95)
			dd = $urandom_range(1) ? int'($urandom_range(2048, 257))
				: -int'($urandom_range(2047, 256));
		else
			dd = int'($urandom);
		queue_delta_sample(dd, x);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_samples.size() != 0 || sample_bus.valid || expected_chunks.size() != 0);
	endtask

	task automatic write_capacity(input logic [11:0] cap);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		cap_model  = cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// sample driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
		end else begin
			if (sample_fire) begin
				encode_sample(sample_bus.timestamp, sample_bus.value_bits);
				pending_samples.delete(0);
				samples_taken <= samples_taken + 1;
			end
			if (!sample_bus.valid || sample_fire) begin
				if (pending_samples.size() != 0 && (calm_window || $urandom_range(99) >= 15)) begin
					sample_bus.valid      <= 1'b1;
					sample_bus.timestamp  <= pending_samples[0].timestamp;
					sample_bus.value_bits <= pending_samples[0].value_bits;
				end else begin
					sample_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// chunk monitor
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			chunk_bus.ready <= 1'b0;
		end else begin
			if (chunk_fire) begin
				if (expected_chunks.size() == 0) begin
					$error("chunk with no sample behind it: value 0x%0h length %0d",
						chunk_bus.chunk_value, chunk_bus.chunk_length);
					mismatches++;
				end else begin
					want = expected_chunks.pop_front();
					check_field("chunk_value", want.value, chunk_bus.chunk_value);
					check_field("chunk_length", want.length, chunk_bus.chunk_length);
					check_field("rejected", want.rejected, chunk_bus.rejected);
					check_field("last", want.last, chunk_bus.last);
				end
			end
			// one long output stall so the job queue backs up into the input
			if (hold_armed && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				chunk_bus.ready <= 1'b0;
			end else begin
				chunk_bus.ready <= calm_window || ($urandom_range(99) >= 15);
			end
		end
	end

	// no transaction on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || sample_fire || chunk_fire || cfg_we) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("time_series_xor_delta_compressor_unit test failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		int burst_items;
		burst_items           = 0;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		sample_bus.valid      = 1'b0;
		sample_bus.timestamp  = '0;
		sample_bus.value_bits = '0;
		chunk_bus.ready       = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first sample fills the smallest budget exactly
		write_capacity(12'd64);
		queue_sample(32'h8000_0000, 32'hFFFF_FFFF);
		wait_drained();

		write_capacity(CAPACITY_RESET);
		// second sample: delta wider than 20 bits, value change forces a new window
		queue_sample(32'h8010_0064, 32'hFFFF_0FFF);
		queue_delta_sample(0, 32'h0000_0000);
		queue_delta_sample(-63, 32'h00F0_0000);
		queue_delta_sample(64, 32'h0050_0000);
		queue_delta_sample(-64, 32'h0020_0000);
		queue_delta_sample(256, 32'h8000_0001);
		queue_delta_sample(-255, 32'hFFFF_FFFF);
		wait_drained();

		write_capacity(12'd2048);
		queue_delta_sample(2048, 32'h8000_0000);
		queue_delta_sample(-2047, 32'h0000_0001);
		queue_delta_sample(2049, 32'h0000_0000);
		queue_delta_sample(-256, 32'h0000_0F00);
		queue_delta_sample(65, 32'h0000_0500);
		queue_delta_sample(257, 32'h0000_0000);
		queue_delta_sample(-2048, 32'hFFFF_FFFF);
		queue_delta_sample(32'sh8000_0000, 32'h0000_0001);
		queue_delta_sample(32'sh7FFF_FFFF, 32'h0000_0000);
		queue_sample(32'h7FFF_FFFF, 32'h0000_0000);
		queue_delta_sample(1, 32'h0000_0000);
		queue_delta_sample(-1, 32'h0000_0000);
		wait_drained();

		hold_armed <= 1'b1;
		repeat (100) queue_random_sample();
		wait_drained();

		// oversized register value, saturates to the parameter
		write_capacity(12'd4095);
		while (!full_model && used_bits < 1700 && burst_items < 80) begin
			repeat (20) queue_random_sample();
			burst_items += 20;
			wait_drained();
		end

		// exact fit of a two-bit sample, then the one that no longer fits
		if (!full_model)
			write_capacity(12'(used_bits + 2));
		queue_delta_sample(0, 32'h0000_0000);
		queue_delta_sample(0, 32'h0000_0000);
		wait_drained();

		// full state holds whatever the budget says
		write_capacity(12'd64);
		repeat ((gen_count < SAMPLE_TARGET - 8) ? SAMPLE_TARGET - gen_count : 8)
			queue_sample($urandom, $urandom);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_chunks.size() == 0)
			$display("time_series_xor_delta_compressor_unit test passed");
		else
			$display("time_series_xor_delta_compressor_unit test failed");
		$finish;
	end

endmodule
